### rtl/core/date_string_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// Date string parser assertion macros
// Concurrent assertion wrappers; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DATE_STRING_PARSER_UNIT_MACROS_SVH
`define DATE_STRING_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define DSPARSE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("date string parser check failed");

`define DSPARSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("date string parser check failed");

`else

`define DSPARSE_ASSERT_SAME(label, clk, rst, ante, cons)

`define DSPARSE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/dsparse_pkg.sv
// ----------------------------------------------------------------------------
// Date string parser package
// Item types, field state type, constants and field arithmetic functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsparse_pkg;

   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam int         RUN_KEEP    = 8;
   localparam logic [3:0] RUN_KEEP_L  = 4'(RUN_KEEP);
   localparam logic [3:0] RUN_LEN_MAX = 4'd14;
   localparam logic [3:0] YEAR_LEN_A  = 4'd4;
   localparam logic [3:0] YEAR_LEN_B  = 4'd8;
   localparam logic [2:0] WIDE_LIMIT  = 3'd4;
   localparam logic [2:0] NARROW_LIMIT = 3'd2;
   localparam logic [1:0] FIELD_YEAR  = 2'd0;
   localparam logic [1:0] FIELD_MONTH = 2'd1;
   localparam logic [1:0] FIELD_DAY   = 2'd2;
   localparam logic [1:0] FIELD_DONE  = 2'd3;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic        bad_date;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  fidx;
      logic [13:0] fval;
      logic [2:0]  fdig;
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
   } fld_state_type;

   function automatic logic wide_year(input logic [3:0] len);
      return len inside {YEAR_LEN_A, YEAR_LEN_B, [RUN_LEN_MAX:4'd15]};
   endfunction

   function automatic logic [6:0] dec2(input logic [3:0] a, input logic [3:0] b);
      return 7'(7'(a) * 7'd10 + 7'(b));
   endfunction

   function automatic logic [13:0] dec4(input logic [3:0] a, input logic [3:0] b,
                                        input logic [3:0] c, input logic [3:0] e);
      return 14'(14'(a) * 14'd1000 + 14'(b) * 14'd100 + 14'(c) * 14'd10 + 14'(e));
   endfunction

   function automatic fld_state_type close_field(input fld_state_type st);
      fld_state_type r;
      r = st;
      if (st.fdig != 3'd0) begin
         case (st.fidx)
            FIELD_YEAR:  r.year  = st.fval;
            FIELD_MONTH: r.month = st.fval[6:0];
            FIELD_DAY:   r.day   = st.fval[6:0];
            default: ;
         endcase
         if (st.fidx != FIELD_DONE) begin
            r.fidx = st.fidx + 2'd1;
         end
         r.fval = '0;
         r.fdig = '0;
      end
      return r;
   endfunction

   function automatic fld_state_type feed_digit(input fld_state_type st,
                                                input logic [3:0] d,
                                                input logic w4);
      fld_state_type r;
      logic [2:0]    limit;
      r     = st;
      limit = (st.fidx == FIELD_YEAR && w4) ? WIDE_LIMIT : NARROW_LIMIT;
      if (st.fidx != FIELD_DONE) begin
         if (st.fdig >= limit) begin
            r = close_field(st);
         end
         if (r.fidx != FIELD_DONE) begin
            r.fval = 14'((r.fval << 3) + (r.fval << 1) + 14'(d));
            r.fdig = r.fdig + 3'd1;
         end
      end
      return r;
   endfunction

   // split the buffered first run into closed fields
   function automatic fld_state_type flush_run(input logic [31:0] digits,
                                               input logic [3:0] len);
      fld_state_type r;
      logic [3:0]    n;
      r = '0;
      n = (len < RUN_KEEP_L) ? len : RUN_KEEP_L;
      if (wide_year(len)) begin
         r.year = dec4(digits[3:0], digits[7:4], digits[11:8], digits[15:12]);
         r.fidx = FIELD_MONTH;
         if (n >= 4'd5) begin
            r.month = (n == 4'd5) ? 7'(digits[19:16]) : dec2(digits[19:16], digits[23:20]);
            r.fidx  = FIELD_DAY;
         end
         if (n >= 4'd7) begin
            r.day  = (n == 4'd7) ? 7'(digits[27:24]) : dec2(digits[27:24], digits[31:28]);
            r.fidx = FIELD_DONE;
         end
      end else if (n != 4'd0) begin
         r.year = (n == 4'd1) ? 14'(digits[3:0]) : 14'(dec2(digits[3:0], digits[7:4]));
         r.fidx = FIELD_MONTH;
         if (n >= 4'd3) begin
            r.month = (n == 4'd3) ? 7'(digits[11:8]) : dec2(digits[11:8], digits[15:12]);
            r.fidx  = FIELD_DAY;
         end
         if (n >= 4'd5) begin
            r.day  = (n == 4'd5) ? 7'(digits[19:16]) : dec2(digits[19:16], digits[23:20]);
            r.fidx = FIELD_DONE;
         end
      end
      return r;
   endfunction

endpackage

### rtl/core/dsparse_stage.sv
// ----------------------------------------------------------------------------
// Date string parser pipeline stage
// One registered item slot with valid and stall on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsparse_stage #(
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_stall,
   input  item_type in_data,
   output logic     out_valid,
   input  logic     out_stall,
   output item_type out_data
);

   logic     valid_ff, valid_in;
   item_type data_ff, data_in;

   assign in_stall  = valid_ff && out_stall;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (!in_stall) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in = in_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

### rtl/core/dsparse_core.sv
// ----------------------------------------------------------------------------
// Date string parser core
// Per-character scan state update and result formation on the last item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "date_string_parser_unit_macros.svh"

module dsparse_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  dsparse_pkg::req_type in_data,
   output logic                 out_push,
   input  logic                 out_stall,
   output dsparse_pkg::rsp_type out_data
);

   import dsparse_pkg::*;

   typedef enum logic [2:0] {
      PH_SKIP   = 3'b001,
      PH_FIRST  = 3'b010,
      PH_FIELDS = 3'b100
   } phase_type;

   phase_type     phase_ff, phase_in, phase_a;
   logic [31:0]   run_digits_ff, run_digits_in, digits_a, buf_digits;
   logic [3:0]    run_len_ff, run_len_in, len_a, buf_len;
   fld_state_type fld_ff, fld_in, fld_a, fld_b, fld_flush;
   logic          is_digit, in_take;
   logic [3:0]    dval;

   assign in_stall = in_data.last && out_stall;
   assign in_take  = in_valid && !in_stall;
   assign out_push = in_take && in_data.last;

   assign is_digit = in_data.ch inside {[CH_ZERO:CH_NINE]};
   assign dval     = is_digit ? 4'(in_data.ch - CH_ZERO) : 4'd0;

   always_comb begin
      buf_digits = run_digits_ff;
      for (int k = 0; k < RUN_KEEP; k++) begin
         if (run_len_ff == 4'(k)) begin
            buf_digits[4*k +: 4] = dval;
         end
      end
      buf_len = (run_len_ff < RUN_LEN_MAX) ? run_len_ff + 4'd1 : run_len_ff;
   end

   always_comb begin
      phase_a  = phase_ff;
      digits_a = run_digits_ff;
      len_a    = run_len_ff;
      case (phase_ff)
         PH_SKIP: begin
            if (is_digit) begin
               phase_a  = PH_FIRST;
               digits_a = buf_digits;
               len_a    = buf_len;
            end
         end
         PH_FIRST: begin
            if (is_digit) begin
               digits_a = buf_digits;
               len_a    = buf_len;
            end else begin
               phase_a = PH_FIELDS;
            end
         end
         default: ;
      endcase
   end

   assign fld_flush = flush_run(digits_a, len_a);

   always_comb begin
      fld_a = fld_ff;
      case (phase_ff)
         PH_SKIP: ;
         PH_FIRST: begin
            if (!is_digit) begin
               fld_a = fld_flush;
            end
         end
         default: begin
            if (is_digit) begin
               fld_a = feed_digit(fld_ff, dval, wide_year(run_len_ff));
            end else begin
               fld_a = close_field(fld_ff);
            end
         end
      endcase
      fld_b = close_field((phase_a == PH_FIRST) ? fld_flush : fld_a);
   end

   always_comb begin
      out_data = '0;
      if (fld_b.fidx <= FIELD_MONTH || fld_b.month == 7'd0) begin
         out_data.bad_date = 1'b1;
      end else begin
         out_data.year  = fld_b.year;
         out_data.month = fld_b.month;
         out_data.day   = (fld_b.fidx == FIELD_DONE) ? fld_b.day : 7'd1;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      run_digits_in = run_digits_ff;
      run_len_in    = run_len_ff;
      fld_in        = fld_ff;
      if (in_take) begin
         if (in_data.last) begin
            phase_in      = PH_SKIP;
            run_digits_in = '0;
            run_len_in    = '0;
            fld_in        = '0;
         end else begin
            phase_in      = phase_a;
            run_digits_in = digits_a;
            run_len_in    = len_a;
            fld_in        = fld_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SKIP;
         run_digits_ff <= '0;
         run_len_ff    <= '0;
         fld_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         run_digits_ff <= run_digits_in;
         run_len_ff    <= run_len_in;
         fld_ff        <= fld_in;
      end
   end

   `DSPARSE_ASSERT_NEXT(a_clear_after_last, clock, reset, in_take && in_data.last, phase_ff == PH_SKIP && run_len_ff == 4'd0 && fld_ff == '0)
   `DSPARSE_ASSERT_SAME(a_skip_clean, clock, reset, phase_ff == PH_SKIP, run_len_ff == 4'd0 && run_digits_ff == '0 && fld_ff == '0)
   `DSPARSE_ASSERT_SAME(a_first_run_open, clock, reset, phase_ff == PH_FIRST, run_len_ff != 4'd0 && fld_ff.fidx == FIELD_YEAR)
   `DSPARSE_ASSERT_SAME(a_field_digits, clock, reset, phase_ff == PH_FIELDS, fld_ff.fdig <= NARROW_LIMIT && fld_ff.fidx != FIELD_YEAR)

endmodule

### rtl/core/date_string_parser_unit.sv
// ----------------------------------------------------------------------------
// Date string parser unit
// Parses a date string of one character per item into year, month and day.
// ----------------------------------------------------------------------------
// The core forms each result on the last character; the output stage registers it.
// Throughput: one character per cycle while not stalled; the scan state is registered.
// Reset: synchronous; clears both stages and the scan state, no clearing pass.
`timescale 1ns / 1ps

module date_string_parser_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dsparse_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dsparse_pkg::rsp_type rsp_data
);

   import dsparse_pkg::*;

   logic    core_valid, core_stall, res_push, res_stall;
   req_type core_req;
   rsp_type res_data;

   dsparse_stage #(.item_type(req_type)) u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (core_valid),
      .out_stall (core_stall),
      .out_data  (core_req)
   );

   dsparse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (core_valid),
      .in_stall  (core_stall),
      .in_data   (core_req),
      .out_push  (res_push),
      .out_stall (res_stall),
      .out_data  (res_data)
   );

   dsparse_stage #(.item_type(rsp_type)) u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_push),
      .in_stall  (res_stall),
      .in_data   (res_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

### bench/date_string_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date string parser unit testbench
// Streams date strings one character per item through the parser and checks
// every year, month, day and bad-date result against a local parse of the
// same characters or a table row's listed result. A short table of hand-picked
// strings comes first, then random strings, mostly well formed with some
// noise. Both sides idle in random bursts until the last stretch of the run.
// ----------------------------------------------------------------------------

module date_string_parser_unit_tb;

   import dsparse_pkg::*;

   localparam int RANDOM_ITEMS = 1650;
   localparam int CALM_ITEMS   = 150;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int TABLE_ROWS   = 24;

   typedef enum logic [2:0] {
      SCAN_SKIP   = 3'b001,
      SCAN_LEAD   = 3'b010,
      SCAN_FIELDS = 3'b100
   } scan_phase_type;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
      logic    drain_first;
   } char_slot_type;

   logic    clock;
   logic    reset;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   char_slot_type table_rows [TABLE_ROWS];
   char_slot_type char_q [$];
   rsp_type       owed_dates [$];

   int send_idx;
   int send_gap;
   int recv_gap;
   int calm_from;
   int idle_cycles;
   int err_count;
   int dates_owed;
   bit all_sent;
   bit send_busy;
   bit recv_busy;

   // parse state
   scan_phase_type phase_q;
   logic [31:0]    lead_digits;
   logic [3:0]     lead_len;
   logic [1:0]     fld_idx;
   logic [13:0]    fld_acc;
   logic [2:0]     fld_cnt;
   logic [13:0]    got_year;
   logic [6:0]     got_month;
   logic [6:0]     got_day;

   date_string_parser_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic clear_parse();
      phase_q     = SCAN_SKIP;
      lead_digits = '0;
      lead_len    = '0;
      fld_idx     = FIELD_YEAR;
      fld_acc     = '0;
      fld_cnt     = '0;
      got_year    = '0;
      got_month   = '0;
      got_day     = '0;
   endtask

   task automatic close_fld();
      if (fld_cnt != 3'd0) begin
         case (fld_idx)
            FIELD_YEAR:  got_year  = fld_acc;
            FIELD_MONTH: got_month = fld_acc[6:0];
            FIELD_DAY:   got_day   = fld_acc[6:0];
            default: ;
         endcase
         if (fld_idx != FIELD_DONE) begin
            fld_idx = fld_idx + 2'd1;
         end
         fld_acc = '0;
         fld_cnt = '0;
      end
   endtask

   task automatic push_digit(input logic [3:0] d);
      logic       wide;
      logic [2:0] cap;
      wide = lead_len == YEAR_LEN_A || lead_len == YEAR_LEN_B || lead_len >= RUN_LEN_MAX;
      cap  = (fld_idx == FIELD_YEAR && wide) ? WIDE_LIMIT : NARROW_LIMIT;
      if (fld_idx != FIELD_DONE) begin
         if (fld_cnt >= cap) begin
            close_fld();
         end
         if (fld_idx != FIELD_DONE) begin
            fld_acc = 14'(fld_acc * 10 + d);
            fld_cnt = fld_cnt + 3'd1;
         end
      end
   endtask

   task automatic stash_lead(input logic [3:0] d);
      if (lead_len < RUN_KEEP_L) begin
         lead_digits[lead_len * 4 +: 4] = d;
      end
      if (lead_len < RUN_LEN_MAX) begin
         lead_len = lead_len + 4'd1;
      end
   endtask

   task automatic replay_lead();
      int n;
      n = (lead_len < RUN_KEEP_L) ? lead_len : RUN_KEEP;
      for (int k = 0; k < n; k++) begin
         push_digit(lead_digits[k * 4 +: 4]);
      end
   endtask

   task automatic parse_char(input req_type it, output bit fire, output rsp_type res);
      logic       digit;
      logic [3:0] d;
      digit = it.ch >= CH_ZERO && it.ch <= CH_NINE;
      d     = digit ? 4'(it.ch - CH_ZERO) : 4'd0;
      fire  = 1'b0;
      res   = '0;
      case (phase_q)
         SCAN_SKIP: begin
            if (digit) begin
               phase_q = SCAN_LEAD;
               stash_lead(d);
            end
         end
         SCAN_LEAD: begin
            if (digit) begin
               stash_lead(d);
            end else begin
               replay_lead();
               close_fld();
               phase_q = SCAN_FIELDS;
            end
         end
         default: begin
            if (digit) begin
               push_digit(d);
            end else begin
               close_fld();
            end
         end
      endcase
      if (it.last) begin
         if (phase_q == SCAN_LEAD) begin
            replay_lead();
         end
         close_fld();
         fire = 1'b1;
         if (fld_idx <= FIELD_MONTH || got_month == 7'd0) begin
            res.bad_date = 1'b1;
         end else begin
            res.year  = got_year;
            res.month = got_month;
            res.day   = (fld_idx == FIELD_DONE) ? got_day : 7'd1;
         end
         clear_parse();
      end
   endtask

   function automatic logic [7:0] any_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] pick_sep();
      logic [7:0] c;
      case ($urandom_range(0, 5))
         0: c = "-";
         1: c = "/";
         2: c = ".";
         default: begin
            c = 8'($urandom_range(0, 245));
            if (c >= CH_ZERO) begin
               c = c + 8'd10;
            end
         end
      endcase
      return c;
   endfunction

   initial begin : build_and_reset
      logic [7:0] text [$];
      int         counted;
      int         skip_n;
      int         n;
      bit         drain;
      bit         mid_done;
      reset = 1'b1;
      table_rows = '{
         {8'h00, 1'b1, 1'b1, 14'd0,    7'd0,  7'd0,  1'b1, 1'b0},
         {8'hFF, 1'b1, 1'b1, 14'd0,    7'd0,  7'd0,  1'b1, 1'b0},
         {"9",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"/",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"9",   1'b1, 1'b1, 14'd9,    7'd9,  7'd1,  1'b0, 1'b0},
         {"1",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"/",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"0",   1'b1, 1'b1, 14'd0,    7'd0,  7'd0,  1'b1, 1'b0},
         {"9",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"9",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"9",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"9",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"9",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"9",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"9",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"9",   1'b1, 1'b1, 14'd9999, 7'd99, 7'd99, 1'b0, 1'b0},
         {"a",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"1",   1'b0, 1'b0, 29'd0,                        1'b0},
         {":",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"2",   1'b0, 1'b0, 29'd0,                        1'b0},
         {":",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"3",   1'b0, 1'b0, 29'd0,                        1'b0},
         {":",   1'b0, 1'b0, 29'd0,                        1'b0},
         {"4",   1'b1, 1'b1, 14'd1,    7'd2,  7'd3,  1'b0, 1'b0}
      };
      for (int i = 0; i < TABLE_ROWS; i++) begin
         char_q.push_back(table_rows[i]);
      end
      counted  = 0;
      mid_done = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         text.delete();
         skip_n = 0;
         if ($urandom_range(0, 9) < 2) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
               case ($urandom_range(0, 3))
                  0:       text.push_back(8'($urandom_range(0, 255)));
                  1:       text.push_back(pick_sep());
                  default: text.push_back(any_digit());
               endcase
            end
         end else begin
            skip_n = $urandom_range(0, 2);
            repeat (skip_n) text.push_back(pick_sep());
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            repeat (n) text.push_back(any_digit());
            repeat ($urandom_range(0, 4)) begin
               repeat ($urandom_range(1, 2)) text.push_back(pick_sep());
               repeat ($urandom_range(1, 3)) text.push_back(any_digit());
            end
            if ($urandom_range(0, 4) == 0) begin
               text.push_back(pick_sep());
            end
         end
         // let the pipe run dry before the random part and once midway
         drain = counted == 0 || (counted >= RANDOM_ITEMS / 2 && !mid_done);
         if (drain && counted != 0) begin
            mid_done = 1'b1;
         end
         for (int k = 0; k < text.size(); k++) begin
            char_q.push_back({text[k], k == text.size() - 1, 1'b0, 29'd0, drain && k == 0});
         end
         counted += text.size();
      end
      calm_from = char_q.size() - CALM_ITEMS;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin : handshake
      int      nxt;
      bit      fire;
      bit      calm;
      bit      moved;
      rsp_type res;
      rsp_type want;
      if (reset) begin
         req_valid   <= 1'b0;
         rsp_stall   <= 1'b0;
         send_idx    <= 0;
         send_gap    <= 0;
         recv_gap    <= 0;
         send_busy   <= 1'b1;
         recv_busy   <= 1'b1;
         idle_cycles <= 0;
         err_count   = 0;
         dates_owed  = 0;
         all_sent    = 1'b0;
         owed_dates.delete();
         clear_parse();
      end else begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (owed_dates.size() == 0) begin
               $display("%0t: unexpected result year %0d month %0d day %0d bad %0b", $time,
                        rsp_data.year, rsp_data.month, rsp_data.day, rsp_data.bad_date);
               err_count++;
            end else begin
               want = owed_dates.pop_front();
               if (rsp_data.year != want.year) begin
                  $display("%0t: year expected %0d, got %0d", $time, want.year, rsp_data.year);
                  err_count++;
               end
               if (rsp_data.month != want.month) begin
                  $display("%0t: month expected %0d, got %0d", $time, want.month,
                           rsp_data.month);
                  err_count++;
               end
               if (rsp_data.day != want.day) begin
                  $display("%0t: day expected %0d, got %0d", $time, want.day, rsp_data.day);
                  err_count++;
               end
               if (rsp_data.bad_date != want.bad_date) begin
                  $display("%0t: bad_date expected %0b, got %0b", $time, want.bad_date,
                           rsp_data.bad_date);
                  err_count++;
               end
            end
         end

         nxt = send_idx;
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            parse_char(req_data, fire, res);
            if (fire) begin
               if (char_q[send_idx].typed) begin
                  res = char_q[send_idx].want;
               end
               owed_dates.push_back(res);
            end
            nxt = send_idx + 1;
         end
         calm = nxt >= calm_from;

         if ($urandom_range(0, 99) == 0) begin
            send_busy <= !send_busy;
         end
         if ($urandom_range(0, 99) == 0) begin
            recv_busy <= !recv_busy;
         end

         if (req_valid && req_stall) begin
            // hold the stalled item
         end else if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (nxt >= char_q.size()) begin
            req_valid <= 1'b0;
         end else if (char_q[nxt].drain_first && owed_dates.size() != 0) begin
            req_valid <= 1'b0;
         end else if (!calm && send_busy && $urandom_range(0, 9) == 0) begin
            req_valid <= 1'b0;
            send_gap  <= $urandom_range(0, 16);
         end else begin
            req_valid <= 1'b1;
            req_data  <= char_q[nxt].item;
         end
         send_idx <= nxt;

         if (recv_gap != 0) begin
            rsp_stall <= 1'b1;
            recv_gap  <= recv_gap - 1;
         end else if (!calm && recv_busy && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            recv_gap  <= $urandom_range(0, 16);
         end else begin
            rsp_stall <= 1'b0;
         end

         idle_cycles <= moved ? 0 : idle_cycles + 1;
         dates_owed = owed_dates.size();
         all_sent   = nxt >= char_q.size();
      end
   end

   initial begin : finish_run
      wait (all_sent && dates_owed == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      wait (idle_cycles >= STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/dsparse_pkg.sv
rtl/core/dsparse_stage.sv
rtl/core/dsparse_core.sv
rtl/core/date_string_parser_unit.sv
bench/date_string_parser_unit_tb.sv
